// ===== rtl/ows_pkg.sv =====
// ----------------------------------------------------------------------------
// ows_pkg
// Types, codes and slot timing constants shared by the 1-wire slot engine.
// ----------------------------------------------------------------------------
package ows_pkg;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_RESET = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  localparam logic [8:0] RST_LOW_TICKS    = 9'd500;
  localparam logic [8:0] RST_SAMPLE_TICKS = 9'd70;
  localparam logic [8:0] RST_REC_TICKS    = 9'd430;
  localparam logic [8:0] W1_LOW_TICKS     = 9'd6;
  localparam logic [8:0] W1_REL_TICKS     = 9'd64;
  localparam logic [8:0] W0_LOW_TICKS     = 9'd60;
  localparam logic [8:0] W0_REL_TICKS     = 9'd10;
  localparam logic [8:0] RD_LOW_TICKS     = 9'd5;
  localparam logic [8:0] RD_REL_TICKS     = 9'd15;
  localparam logic [2:0] LAST_BIT         = 3'd7;

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_LOW = 2'd0,
    PH_REL = 2'd1,
    PH_REC = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       line_in;
  } req_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       rejected;
  } rsp_item_t;

  typedef struct packed {
    logic       is_cmd;
    op_t        op;
    logic [7:0] data_byte;
    logic       line_in;
  } cmd_t;

endpackage

// ===== rtl/ows_front.sv =====
// ----------------------------------------------------------------------------
// ows_front
// Input stage that registers each item and classifies it as a tick or a
// command for the slot sequencer.
// ----------------------------------------------------------------------------
module ows_front import ows_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  req_item_t req_item,
  input  logic      req_valid,
  output logic      req_ready,
  output cmd_t      cmd,
  output logic      cmd_valid,
  input  logic      cmd_ready
);

  cmd_t cmd_next;

  assign req_ready = !cmd_valid || cmd_ready;

  always_comb begin
    cmd_next.data_byte = req_item.data_byte;
    cmd_next.line_in   = req_item.line_in;
    unique case (req_item.req_type)
      REQ_TICK: begin
        cmd_next.is_cmd = 1'b0;
        cmd_next.op     = OP_IDLE;
      end
      REQ_RESET: begin
        cmd_next.is_cmd = 1'b1;
        cmd_next.op     = OP_RESET;
      end
      REQ_WRITE: begin
        cmd_next.is_cmd = 1'b1;
        cmd_next.op     = OP_WRITE;
      end
      default: begin
        cmd_next.is_cmd = 1'b1;
        cmd_next.op     = OP_READ;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (req_ready) begin
      cmd_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      cmd <= cmd_next;
    end
  end

endmodule

// ===== rtl/ows_queue.sv =====
// ----------------------------------------------------------------------------
// ows_queue
// Two-entry queue between the classifying front end and the slot sequencer.
// ----------------------------------------------------------------------------
module ows_queue import ows_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t push_item,
  input  logic push_valid,
  output logic push_ready,
  output cmd_t pop_item,
  output logic pop_valid,
  input  logic pop_ready
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/ows_back.sv =====
// ----------------------------------------------------------------------------
// ows_back
// Slot sequencer that times reset, write and read slots one tick at a time
// and holds each result in an output register.
// ----------------------------------------------------------------------------
module ows_back import ows_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  output rsp_item_t rsp_item,
  output logic      rsp_valid,
  input  logic      rsp_ready
);

  op_t        operation;
  op_t        operation_next;
  phase_t     phase;
  phase_t     phase_next;
  logic [8:0] tick_count;
  logic [8:0] tick_count_next;
  logic [2:0] bit_index;
  logic [2:0] bit_index_next;
  logic [7:0] shift_byte;
  logic [7:0] shift_byte_next;
  logic       presence_flag;
  logic       presence_flag_next;
  logic [7:0] last_read;
  logic [7:0] last_read_next;
  rsp_item_t  rsp_next;
  logic [8:0] tick_inc;
  logic       done;
  logic       rej;
  logic       pop;

  assign cmd_ready = !rsp_valid || rsp_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign tick_inc  = tick_count + 9'd1;

  always_comb begin
    operation_next     = operation;
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    presence_flag_next = presence_flag;
    last_read_next     = last_read;
    done               = 1'b0;
    rej                = 1'b0;

    if (!cmd.is_cmd) begin
      if (operation != OP_IDLE) begin
        tick_count_next = tick_inc;
        unique case (operation)
          OP_RESET: begin
            unique case (phase)
              PH_LOW: begin
                if (tick_inc >= RST_LOW_TICKS) begin
                  phase_next      = PH_REL;
                  tick_count_next = 9'd0;
                end
              end
              PH_REL: begin
                if (tick_inc >= RST_SAMPLE_TICKS) begin
                  presence_flag_next = !cmd.line_in;
                  phase_next         = PH_REC;
                  tick_count_next    = 9'd0;
                end
              end
              PH_REC: done = (tick_inc >= RST_REC_TICKS);
              default: done = 1'b1;
            endcase
          end
          OP_WRITE: begin
            unique case (phase)
              PH_LOW: begin
                if (tick_inc >= (shift_byte[0] ? W1_LOW_TICKS : W0_LOW_TICKS)) begin
                  phase_next      = PH_REL;
                  tick_count_next = 9'd0;
                end
              end
              PH_REL: begin
                if (tick_inc >= (shift_byte[0] ? W1_REL_TICKS : W0_REL_TICKS)) begin
                  shift_byte_next = {1'b0, shift_byte[7:1]};
                  tick_count_next = 9'd0;
                  phase_next      = PH_LOW;
                  if (bit_index == LAST_BIT) begin
                    done = 1'b1;
                  end else begin
                    bit_index_next = bit_index + 3'd1;
                  end
                end
              end
              default: done = 1'b1;
            endcase
          end
          default: begin
            unique case (phase)
              PH_LOW: begin
                if (tick_inc >= RD_LOW_TICKS) begin
                  phase_next      = PH_REL;
                  tick_count_next = 9'd0;
                end
              end
              PH_REL: begin
                if (tick_inc >= RD_REL_TICKS) begin
                  shift_byte_next            = shift_byte;
                  shift_byte_next[bit_index] = shift_byte[bit_index] | cmd.line_in;
                  tick_count_next            = 9'd0;
                  phase_next                 = PH_LOW;
                  if (bit_index == LAST_BIT) begin
                    last_read_next = shift_byte_next;
                    done           = 1'b1;
                  end else begin
                    bit_index_next = bit_index + 3'd1;
                  end
                end
              end
              default: done = 1'b1;
            endcase
          end
        endcase
        if (done) begin
          operation_next  = OP_IDLE;
          phase_next      = PH_LOW;
          tick_count_next = 9'd0;
          bit_index_next  = 3'd0;
        end
      end
    end else if (operation != OP_IDLE) begin
      rej = 1'b1;
    end else begin
      operation_next  = cmd.op;
      phase_next      = PH_LOW;
      tick_count_next = 9'd0;
      bit_index_next  = 3'd0;
      shift_byte_next = (cmd.op == OP_WRITE) ? cmd.data_byte : 8'd0;
    end

    rsp_next.drive_low = (operation_next != OP_IDLE) && (phase_next == PH_LOW);
    rsp_next.busy_res  = (operation_next != OP_IDLE);
    rsp_next.done_res  = done;
    rsp_next.presence  = presence_flag_next;
    rsp_next.read_data = last_read_next;
    rsp_next.rejected  = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      operation     <= OP_IDLE;
      phase         <= PH_LOW;
      tick_count    <= 9'd0;
      bit_index     <= 3'd0;
      shift_byte    <= 8'd0;
      presence_flag <= 1'b0;
      last_read     <= 8'd0;
    end else if (pop) begin
      operation     <= operation_next;
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      presence_flag <= presence_flag_next;
      last_read     <= last_read_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd_ready) begin
      rsp_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp_item <= rsp_next;
    end
  end

endmodule

// ===== rtl/one_wire_master_slot_engine.sv =====
// ----------------------------------------------------------------------------
// one_wire_master_slot_engine
// An accepted item passes the front register, a queue entry and the
// sequencer's output register before its result is valid.
// Throughput is one item per cycle unless rsp_ready stalls the output, since
// each item only steps counters and a shift register in the sequencer.
// Synchronous reset returns the bus to idle with presence and read data zero.
// A 1-wire bus master working at time-slot level: a front end classifies
// ticks and commands, a short queue decouples it from the slot sequencer.
// ----------------------------------------------------------------------------
module one_wire_master_slot_engine import ows_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  req_item_t req_item,
  input  logic      req_valid,
  output logic      req_ready,
  output rsp_item_t rsp_item,
  output logic      rsp_valid,
  input  logic      rsp_ready
);

  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;
  cmd_t queue_cmd;
  logic queue_valid;
  logic queue_ready;

  ows_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_item  (req_item),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready)
  );

  ows_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (front_cmd),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_item   (queue_cmd),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready)
  );

  ows_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (queue_cmd),
    .cmd_valid (queue_valid),
    .cmd_ready (queue_ready),
    .rsp_item  (rsp_item),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

endmodule
